@@ hdl/iwn_pkg.sv @@
// Package for the intensity window normalizer.
// Holds sizes, register indexes and the controller state type; no dependencies.
package iwn_pkg;

  localparam int MAX_SAMPLES = 4096;
  localparam int ADDR_W      = $clog2(MAX_SAMPLES);
  localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);

  // Shared serial divider sizes.
  localparam int DIV_W     = 72;
  localparam int DVS_W     = 26;
  localparam int DIV_CNT_W = $clog2(DIV_W);

  localparam int WIN_W     = 25;
  localparam int SQRT_STEPS = 24;

  localparam logic [1:0] REG_MODE       = 2'd0;
  localparam logic [1:0] REG_PARAM_LOW  = 2'd1;
  localparam logic [1:0] REG_PARAM_HIGH = 2'd2;

  localparam logic [1:0] MODE_MIN_MAX = 2'd0;
  localparam logic [1:0] MODE_STD     = 2'd1;

  localparam logic [0:0] CMD_LOAD = 1'b0;
  localparam logic [0:0] CMD_READ = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLOSE,
    ST_MUL_SQ,
    ST_MUL_NLO,
    ST_MUL_NHI,
    ST_DIFF,
    ST_VAR_GO,
    ST_VAR_WAIT,
    ST_SQRT,
    ST_MEAN_GO,
    ST_MEAN_WAIT,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_WINDOW,
    ST_READ,
    ST_SCALE_WAIT
  } state_t;

endpackage

@@ hdl/image_intensity_window_normalize_top.sv @@
// Intensity window normalizer top level: sample store, statistics and controller.
// Depends on iwn_pkg, iwn_ram and iwn_div.
//
// Usage: a command is taken when start is high and busy is low. A load command
// (command = 0) writes sample into the frame store and updates min, max, sum
// and sum of squares; busy stays low unless last_sample is set.
// A load with last_sample closes the frame and computes the window: mode 0
// takes it from min and max, modes 2 and 3 and mode 1 on an empty frame from
// the params, and mode 1 otherwise through the serial divider twice and the
// 24-step square root. A read command (command = 1) returns one word: valid
// pulses for exactly one cycle with scaled, frame_end and no_data. A read with
// no frame or past the end answers on the next cycle. A normal read scales its
// sample through the serial divider; an inverted window returns full scale.
// Configuration words go through cfg_valid/cfg_data at cfg_index; cfg_ready
// is always high, and writes are meant only while busy is low.
// Reset clears the frame, statistics, window and registers to their defaults;
// the store itself is not cleared. The receiver cannot stall: each result is
// shown once and then dropped.
module image_intensity_window_normalize_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        command,
  input  logic signed [15:0] sample,
  input  logic        last_sample,
  output logic        valid,
  output logic [16:0] scaled,
  output logic        frame_end,
  output logic        no_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_data
);
  import iwn_pkg::*;

  state_t state, state_next;

  logic [1:0]               mode;
  logic signed [23:0]       param_low, param_high;
  logic [CNT_W-1:0]         sample_count, read_pointer;
  logic signed [15:0]       running_min, running_max;
  logic signed [28:0]       running_sum;
  logic [42:0]              running_sum_squares;
  logic                     frame_closed;
  logic signed [WIN_W-1:0]  window_low, window_high;

  logic [55:0]              s2, dvar;
  logic [25:0]              nsq;
  logic [34:0]              p_lo;
  logic [33:0]              p_hi;
  logic [47:0]              sq_rem, sq_res, sq_bit;
  logic [4:0]               sq_cnt;
  logic signed [25:0]       mean;
  logic signed [49:0]       prod_lo, prod_hi;

  // Controller outputs.
  logic accept, do_load, do_read, store_ok, read_empty, div_start;
  logic [CNT_W-1:0] eff_count;

  logic [DIV_W-1:0] div_dividend, div_quotient;
  logic [DVS_W-1:0] div_divisor, div_remainder;
  logic             div_done;

  logic [15:0]      ram_rdata;

  logic signed [31:0] samp_sq;
  logic signed [57:0] sum_sq_full;
  logic [28:0]        sum_mag;
  logic [48:0]        sq_trial;
  logic               sq_fits;
  logic signed [25:0] mean_q;
  logic signed [50:0] lo_full, hi_full;
  logic signed [WIN_W-1:0] xs, xc;
  logic signed [WIN_W:0]   wdiff, xdiff;
  logic [WIN_W-1:0]   width_eff;
  logic               inverted;

  localparam logic signed [50:0] WIN_MAX = 51'sd16777215;
  localparam logic signed [50:0] WIN_MIN = -51'sd16777216;

  assign busy      = state != ST_IDLE;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;
  assign do_load   = accept && (command == CMD_LOAD);
  assign do_read   = accept && (command == CMD_READ);
  assign eff_count = frame_closed ? '0 : sample_count;
  assign store_ok  = eff_count < CNT_W'(MAX_SAMPLES);
  assign read_empty = !frame_closed || (read_pointer >= sample_count);

  assign samp_sq     = sample * sample;
  assign sum_sq_full = running_sum * running_sum;
  assign sum_mag     = running_sum[28] ? 29'(-running_sum) : 29'(running_sum);

  assign sq_trial = {1'b0, sq_res} + {1'b0, sq_bit};
  assign sq_fits  = {1'b0, sq_rem} >= sq_trial;

  assign mean_q  = 26'(div_quotient);
  assign lo_full = 51'(mean) - 51'(prod_lo >>> 8);
  assign hi_full = 51'(mean) + 51'(prod_hi >>> 8);

  // Scaling datapath for the sample read out of the store.
  assign inverted = window_low > window_high;
  assign xs       = {{(WIN_W-24){ram_rdata[15]}}, ram_rdata, 8'b0};
  always_comb begin
    xc = xs;
    if (xs < window_low)  xc = window_low;
    if (xs > window_high) xc = window_high;
  end
  assign xdiff     = (WIN_W+1)'(xc) - (WIN_W+1)'(window_low);
  assign wdiff     = (WIN_W+1)'(window_high) - (WIN_W+1)'(window_low);
  assign width_eff = (wdiff == '0) ? WIN_W'(1) : wdiff[WIN_W-1:0];

  always_comb begin
    div_dividend = '0;
    div_divisor  = '0;
    unique case (state)
      ST_VAR_GO: begin
        div_dividend = DIV_W'({dvar, 16'b0});
        div_divisor  = nsq;
      end
      ST_MEAN_GO: begin
        div_dividend = DIV_W'({sum_mag, 8'b0});
        div_divisor  = DVS_W'(sample_count);
      end
      default: begin
        div_dividend = DIV_W'({xdiff[WIN_W-1:0], 16'b0});
        div_divisor  = DVS_W'(width_eff);
      end
    endcase
  end

  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (do_load && last_sample) state_next = ST_CLOSE;
        else if (do_read && !read_empty) state_next = ST_READ;
      end
      ST_CLOSE: begin
        if (mode == MODE_STD && sample_count != '0) state_next = ST_MUL_SQ;
        else state_next = ST_IDLE;
      end
      ST_MUL_SQ:  state_next = ST_MUL_NLO;
      ST_MUL_NLO: state_next = ST_MUL_NHI;
      ST_MUL_NHI: state_next = ST_DIFF;
      ST_DIFF:    state_next = ST_VAR_GO;
      ST_VAR_GO: begin
        div_start  = 1'b1;
        state_next = ST_VAR_WAIT;
      end
      ST_VAR_WAIT: if (div_done) state_next = ST_SQRT;
      ST_SQRT:     if (sq_cnt == '0) state_next = ST_MEAN_GO;
      ST_MEAN_GO: begin
        div_start  = 1'b1;
        state_next = ST_MEAN_WAIT;
      end
      ST_MEAN_WAIT: if (div_done) state_next = ST_MUL_LO;
      ST_MUL_LO:  state_next = ST_MUL_HI;
      ST_MUL_HI:  state_next = ST_WINDOW;
      ST_WINDOW:  state_next = ST_IDLE;
      ST_READ: begin
        if (inverted) begin
          state_next = ST_IDLE;
        end else begin
          div_start  = 1'b1;
          state_next = ST_SCALE_WAIT;
        end
      end
      ST_SCALE_WAIT: if (div_done) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= MODE_MIN_MAX;
      param_low  <= '0;
      param_high <= 24'sd256;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_MODE:       mode       <= cfg_data[1:0];
        REG_PARAM_LOW:  param_low  <= cfg_data;
        REG_PARAM_HIGH: param_high <= cfg_data;
        default: ;
      endcase
    end
  end

  // Frame control, statistics, window and result registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count        <= '0;
      read_pointer        <= '0;
      frame_closed        <= 1'b0;
      running_min         <= '0;
      running_max         <= '0;
      running_sum         <= '0;
      running_sum_squares <= '0;
      window_low          <= '0;
      window_high         <= '0;
      valid               <= 1'b0;
      scaled              <= '0;
      frame_end           <= 1'b0;
      no_data             <= 1'b0;
    end else begin
      valid <= 1'b0;
      if (do_load) begin
        sample_count <= eff_count;
        read_pointer <= '0;
        frame_closed <= last_sample;
        if (store_ok) begin
          sample_count <= eff_count + 1'b1;
          if (eff_count == '0) begin
            running_min         <= sample;
            running_max         <= sample;
            running_sum         <= 29'(sample);
            running_sum_squares <= 43'(unsigned'(samp_sq));
          end else begin
            if (sample < running_min) running_min <= sample;
            if (sample > running_max) running_max <= sample;
            running_sum         <= running_sum + 29'(sample);
            running_sum_squares <= running_sum_squares + 43'(unsigned'(samp_sq));
          end
        end
      end
      if (do_read && read_empty) begin
        valid     <= 1'b1;
        scaled    <= '0;
        frame_end <= 1'b0;
        no_data   <= 1'b1;
      end
      if (state == ST_CLOSE && !(mode == MODE_STD && sample_count != '0)) begin
        if (mode == MODE_MIN_MAX) begin
          window_low  <= {{(WIN_W-24){running_min[15]}}, running_min, 8'b0};
          window_high <= {{(WIN_W-24){running_max[15]}}, running_max, 8'b0};
        end else begin
          window_low  <= WIN_W'(param_low);
          window_high <= WIN_W'(param_high);
        end
      end
      if (state == ST_WINDOW) begin
        priority if (lo_full > WIN_MAX) window_low <= WIN_W'(WIN_MAX);
        else if (lo_full < WIN_MIN)     window_low <= WIN_W'(WIN_MIN);
        else                            window_low <= WIN_W'(lo_full);
        priority if (hi_full > WIN_MAX) window_high <= WIN_W'(WIN_MAX);
        else if (hi_full < WIN_MIN)     window_high <= WIN_W'(WIN_MIN);
        else                            window_high <= WIN_W'(hi_full);
      end
      if ((state == ST_READ && inverted) || (state == ST_SCALE_WAIT && div_done)) begin
        valid        <= 1'b1;
        scaled       <= inverted ? 17'd65536 : div_quotient[16:0];
        frame_end    <= (read_pointer + 1'b1) == sample_count;
        no_data      <= 1'b0;
        read_pointer <= read_pointer + 1'b1;
      end
    end
  end

  // Mode 1 arithmetic: variance, square root, mean and the two offsets.
  always_ff @(posedge clk) begin
    unique case (state)
      ST_MUL_SQ: begin
        s2  <= 56'(unsigned'(sum_sq_full));
        nsq <= 26'(sample_count) * 26'(sample_count);
      end
      ST_MUL_NLO: p_lo <= 35'(sample_count) * 35'(running_sum_squares[21:0]);
      ST_MUL_NHI: p_hi <= 34'(sample_count) * 34'(running_sum_squares[42:22]);
      ST_DIFF:    dvar <= 56'({p_hi, 22'b0}) + 56'(p_lo) - s2;
      ST_VAR_WAIT: begin
        sq_rem <= div_quotient[47:0];
        sq_res <= '0;
        sq_bit <= 48'(1) << 46;
        sq_cnt <= 5'(SQRT_STEPS - 1);
      end
      ST_SQRT: begin
        if (sq_fits) begin
          sq_rem <= sq_rem - sq_trial[47:0];
          sq_res <= (sq_res >> 1) + sq_bit;
        end else begin
          sq_res <= sq_res >> 1;
        end
        sq_bit <= sq_bit >> 2;
        sq_cnt <= sq_cnt - 1'b1;
      end
      ST_MEAN_WAIT: begin
        if (div_done) begin
          mean <= running_sum[28] ? -(mean_q + 26'(div_remainder != '0)) : mean_q;
        end
      end
      ST_MUL_LO: prod_lo <= param_low * $signed({1'b0, sq_res[24:0]});
      ST_MUL_HI: prod_hi <= param_high * $signed({1'b0, sq_res[24:0]});
      default: ;
    endcase
  end

  iwn_ram #(
    .WIDTH(16),
    .DEPTH(MAX_SAMPLES)
  ) u_store (
    .clk  (clk),
    .we   (do_load && store_ok),
    .waddr(eff_count[ADDR_W-1:0]),
    .wdata(sample),
    .raddr(read_pointer[ADDR_W-1:0]),
    .rdata(ram_rdata)
  );

  iwn_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quotient),
    .remainder(div_remainder)
  );

endmodule

@@ hdl/iwn_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module iwn_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hdl/iwn_div.sv @@
// Restoring serial divider, one quotient bit per cycle.
// Depends on iwn_pkg for operand widths.
module iwn_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [iwn_pkg::DIV_W-1:0] dividend,
  input  logic [iwn_pkg::DVS_W-1:0] divisor,
  output logic                      done,
  output logic [iwn_pkg::DIV_W-1:0] quotient,
  output logic [iwn_pkg::DVS_W-1:0] remainder
);
  import iwn_pkg::*;

  logic                 active;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DVS_W-1:0]     dvs;
  logic [DVS_W:0]       trial;
  logic                 fits;

  assign trial = {remainder, quotient[DIV_W-1]};
  assign fits  = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      cnt    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        active <= 1'b1;
        cnt    <= DIV_CNT_W'(DIV_W - 1);
      end else if (active) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient  <= dividend;
      remainder <= '0;
      dvs       <= divisor;
    end else if (active) begin
      // The dividend shifts out the top while quotient bits shift in below.
      quotient  <= {quotient[DIV_W-2:0], fits};
      remainder <= fits ? DVS_W'(trial - {1'b0, dvs}) : trial[DVS_W-1:0];
    end
  end

endmodule
